[hdl/sca_pkg.sv]
// ----------------------------------------------------------------------------
// sca_pkg
// Types and constants shared by the closest approach pipeline.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int POS_W      = 24;
    localparam int DIFF_W     = 25;
    localparam int DEN_W      = 50;
    localparam int FRAC_W     = 17;
    localparam int FRAC_Q_W   = 16;
    localparam int MISS_W     = 24;
    localparam int CLOSURE_W  = 32;
    localparam int TICK_W     = 10;
    localparam int FUZE_W     = 24;
    localparam int SQRT_IN_W  = 58;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int CDIV_DW    = TICK_W + 4;
    localparam int CDIV_QW    = 40;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_MS     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FUZE_RADIUS = 8'd1;

    localparam logic [TICK_W-1:0]    TICK_MS_RESET     = 10'd100;
    localparam logic [FUZE_W-1:0]    FUZE_RADIUS_RESET = 24'd160;
    localparam logic [MISS_W-1:0]    MISS_MAX          = 24'hFFFFFF;
    localparam logic [CLOSURE_W-1:0] CLOSURE_MAX       = 32'hFFFFFFFF;
    localparam logic [FRAC_W-1:0]    ONE_Q16           = 17'h10000;
    localparam logic [9:0]           MS_PER_S          = 10'd1000;

    typedef struct packed {
        logic                        zero;
        logic                        one;
        logic [DEN_W-1:0]            den;
        logic [2:0][POS_W-1:0]       p0;
        logic [2:0][DIFF_W-1:0]      d;
    } frac_side_t;

    typedef struct packed {
        logic [MISS_W-1:0] miss;
        logic              fuze_hit;
        logic [FRAC_W-1:0] frac;
    } close_side_t;

endpackage

[hdl/sca_divider.sv]
// ----------------------------------------------------------------------------
// sca_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sca_divider #(
    parameter int DW = 50,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_div,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_bits,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [QW];
    logic [DW-1:0] div_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [QW-1:0] bits_reg [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          vld_cur;
        logic [DW-1:0] div_cur;
        logic [DW-1:0] rem_cur;
        logic [QW-1:0] quo_cur;
        logic [QW-1:0] bits_cur;
        logic [SW-1:0] side_cur;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;
        logic [QW-1:0] bits_next;

        if (k == 0) begin : g_first
            assign vld_cur  = in_valid;
            assign div_cur  = in_div;
            assign rem_cur  = in_rem;
            assign quo_cur  = '0;
            assign bits_cur = in_bits;
            assign side_cur = in_side;
        end else begin : g_later
            assign vld_cur  = vld_reg[k-1];
            assign div_cur  = div_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign quo_cur  = quo_reg[k-1];
            assign bits_cur = bits_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign trial     = {rem_cur, bits_cur[QW-1]};
        assign diff      = trial - {1'b0, div_cur};
        assign ge        = trial >= {1'b0, div_cur};
        assign rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign quo_next  = {quo_cur[QW-2:0], ge};
        assign bits_next = {bits_cur[QW-2:0], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k]  <= div_cur;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                bits_reg[k] <= bits_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_rem   = rem_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

[hdl/sca_isqrt.sv]
// ----------------------------------------------------------------------------
// sca_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module sca_isqrt #(
    parameter int W  = 58,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [W-1:0]    in_x,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [W/2-1:0]  out_root,
    output logic [SW-1:0]   out_side
);

    localparam int RW = W / 2;

    logic          vld_reg  [RW];
    logic [W-1:0]  x_reg    [RW];
    logic [RW:0]   rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic          vld_cur;
        logic [W-1:0]  x_cur;
        logic [RW:0]   rem_cur;
        logic [RW-1:0] root_cur;
        logic [SW-1:0] side_cur;
        logic [RW+2:0] shifted;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        logic          ge;
        logic [RW:0]   rem_next;
        logic [RW-1:0] root_next;
        logic [W-1:0]  x_next;

        if (k == 0) begin : g_first
            assign vld_cur  = in_valid;
            assign x_cur    = in_x;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = in_side;
        end else begin : g_later
            assign vld_cur  = vld_reg[k-1];
            assign x_cur    = x_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign shifted   = {rem_cur, x_cur[W-1:W-2]};
        assign trial     = {1'b0, root_cur, 2'b01};
        assign diff      = shifted - trial;
        assign ge        = shifted >= trial;
        assign rem_next  = ge ? diff[RW:0] : shifted[RW:0];
        assign root_next = {root_cur[RW-2:0], ge};
        assign x_next    = {x_cur[W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

[hdl/segment_closest_approach.sv]
// ----------------------------------------------------------------------------
// segment_closest_approach
// Closest point of approach on a straight segment, with miss distance,
// closure speed, fraction of the tick and fuze flag.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle; the whole pipeline holds while the
// result register is full and not taken.
// The depth is set by the 16-bit fraction divider, the 29-step square roots
// and the 40-step closure divider, one bit per stage each.
// Reset clears all valid bits and loads tick_ms 100 and fuze_radius 160.
module segment_closest_approach (
    input  logic                                clk,
    input  logic                                rst_n,
    // start_east, start_north, start_up, end_east, end_north, end_up
    input  logic [sca_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // miss_distance, closure_speed, fraction, within_fuze, zero padding
    output logic [sca_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sca_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import sca_pkg::*;

    logic en;

    logic [TICK_W-1:0] tick_reg;
    logic [FUZE_W-1:0] fuze_reg;

    logic                    s1_vld_reg;
    logic [2:0][POS_W-1:0]   s1_p0_reg;
    logic [2:0][DIFF_W-1:0]  s1_d_reg;
    logic [2:0][DIFF_W-1:0]  s1_d_next;

    logic                    s2_vld_reg;
    logic [2:0][POS_W-1:0]   s2_p0_reg;
    logic [2:0][DIFF_W-1:0]  s2_d_reg;
    logic [2:0][48:0]        s2_pd_reg;
    logic [2:0][48:0]        s2_dd_reg;
    logic [2:0][48:0]        s2_pd_next;
    logic [2:0][48:0]        s2_dd_next;

    logic                    s3_vld_reg;
    logic [2:0][POS_W-1:0]   s3_p0_reg;
    logic [2:0][DIFF_W-1:0]  s3_d_reg;
    logic [50:0]             s3_dot_reg;
    logic [DEN_W-1:0]        s3_den_reg;
    logic [50:0]             s3_dot_next;
    logic [DEN_W-1:0]        s3_den_next;

    logic                    s4_vld_reg;
    frac_side_t              s4_side_reg;
    logic [DEN_W-1:0]        s4_rem_reg;
    frac_side_t              s4_side_next;
    logic [DEN_W-1:0]        s4_rem_next;
    logic [50:0]             s4_neg;

    logic                    fd_vld;
    logic [FRAC_Q_W-1:0]     fd_quo;
    logic [DEN_W-1:0]        fd_rem;
    logic [$bits(frac_side_t)-1:0] fd_side_bits;
    frac_side_t              fd_side;

    logic                    s5_vld_reg;
    logic [FRAC_W-1:0]       s5_frac_reg;
    logic [2:0][POS_W-1:0]   s5_p0_reg;
    logic [2:0][DIFF_W-1:0]  s5_d_reg;
    logic [DEN_W-1:0]        s5_den_reg;
    logic [FRAC_W-1:0]       s5_frac_next;

    logic                    s6_vld_reg;
    logic [FRAC_W-1:0]       s6_frac_reg;
    logic [2:0][POS_W-1:0]   s6_p0_reg;
    logic [DEN_W-1:0]        s6_den_reg;
    logic [2:0][42:0]        s6_fd_reg;
    logic [2:0][42:0]        s6_fd_next;

    logic                    s7_vld_reg;
    logic [FRAC_W-1:0]       s7_frac_reg;
    logic [DEN_W-1:0]        s7_den_reg;
    logic [2:0][27:0]        s7_a_reg;
    logic [2:0][27:0]        s7_a_next;

    logic                    s8_vld_reg;
    logic [FRAC_W-1:0]       s8_frac_reg;
    logic [DEN_W-1:0]        s8_den_reg;
    logic [2:0][55:0]        s8_sq_reg;
    logic [2:0][55:0]        s8_sq_next;

    logic                    s9_vld_reg;
    logic [FRAC_W-1:0]       s9_frac_reg;
    logic [DEN_W-1:0]        s9_den_reg;
    logic [55:0]             s9_s_reg;
    logic [55:0]             s9_s_next;

    logic                    sq_vld;
    logic [SQRT_OUT_W-1:0]   sq_miss_root;
    logic [SQRT_OUT_W-1:0]   sq_len_root;
    logic [FRAC_W-1:0]       sq_frac;

    logic                    s10_vld_reg;
    logic [MISS_W-1:0]       s10_miss_reg;
    logic                    s10_fuze_hit_reg;
    logic [FRAC_W-1:0]       s10_frac_reg;
    logic [38:0]             s10_lm_reg;
    logic [SQRT_OUT_W:0]     s10_rounded;
    logic [MISS_W-1:0]       s10_miss_next;

    logic                    s11_vld_reg;
    close_side_t             s11_side_reg;
    logic [CDIV_QW-1:0]      s11_dividend_reg;

    logic                    cd_vld;
    logic [CDIV_QW-1:0]      cd_quo;
    logic [$bits(close_side_t)-1:0] cd_side_bits;
    close_side_t             cd_side;
    logic [CLOSURE_W-1:0]    closure_next;

    logic                    out_vld_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= TICK_MS_RESET;
            fuze_reg <= FUZE_RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TICK_MS)
            begin
                tick_reg <= cfg_data[TICK_W-1:0];
            end
            else if (cfg_index == CFG_FUZE_RADIUS)
            begin
                fuze_reg <= cfg_data[FUZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= fd_vld;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= sq_vld;
            s11_vld_reg <= s10_vld_reg;
            out_vld_reg <= cd_vld;
        end
    end

    // Displacement over the tick.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_d_next[i] = {s_tdata[POS_W*(i+3)+POS_W-1], s_tdata[POS_W*(i+3) +: POS_W]}
                         - {s_tdata[POS_W*i+POS_W-1], s_tdata[POS_W*i +: POS_W]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pd_next[i] = 49'($signed(s1_p0_reg[i])) * 49'($signed(s1_d_reg[i]));
            s2_dd_next[i] = 49'($signed(s1_d_reg[i])) * 49'($signed(s1_d_reg[i]));
        end
    end

    assign s3_dot_next = 51'($signed(s2_pd_reg[0])) + 51'($signed(s2_pd_reg[1]))
                       + 51'($signed(s2_pd_reg[2]));
    assign s3_den_next = 50'(s2_dd_reg[0]) + 50'(s2_dd_reg[1]) + 50'(s2_dd_reg[2]);

    // The fraction is zero for a still segment or one moving away, and one
    // where the closest point lies at or beyond the end of the tick.
    assign s4_neg = -s3_dot_reg;

    always_comb
    begin
        s4_side_next.den  = s3_den_reg;
        s4_side_next.p0   = s3_p0_reg;
        s4_side_next.d    = s3_d_reg;
        s4_side_next.zero = (s3_den_reg == '0) || !s3_dot_reg[50];
        s4_side_next.one  = !s4_side_next.zero && (s4_neg[DEN_W-1:0] >= s3_den_reg);
        s4_rem_next       = (s4_side_next.zero || s4_side_next.one) ? '0 : s4_neg[DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p0_reg   <= {s_tdata[POS_W*2 +: POS_W], s_tdata[POS_W +: POS_W],
                            s_tdata[0 +: POS_W]};
            s1_d_reg    <= s1_d_next;
            s2_p0_reg   <= s1_p0_reg;
            s2_d_reg    <= s1_d_reg;
            s2_pd_reg   <= s2_pd_next;
            s2_dd_reg   <= s2_dd_next;
            s3_p0_reg   <= s2_p0_reg;
            s3_d_reg    <= s2_d_reg;
            s3_dot_reg  <= s3_dot_next;
            s3_den_reg  <= s3_den_next;
            s4_side_reg <= s4_side_next;
            s4_rem_reg  <= s4_rem_next;
        end
    end

    sca_divider #(
        .DW (DEN_W),
        .QW (FRAC_Q_W),
        .SW ($bits(frac_side_t))
    ) u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_vld_reg),
        .in_div    (s4_side_reg.den),
        .in_rem    (s4_rem_reg),
        .in_bits   ('0),
        .in_side   (s4_side_reg),
        .out_valid (fd_vld),
        .out_quo   (fd_quo),
        .out_rem   (fd_rem),
        .out_side  (fd_side_bits)
    );

    assign fd_side = frac_side_t'(fd_side_bits);

    always_comb
    begin
        if (fd_side.zero)
        begin
            s5_frac_next = '0;
        end
        else if (fd_side.one)
        begin
            s5_frac_next = ONE_Q16;
        end
        else
        begin
            s5_frac_next = FRAC_W'(fd_quo)
                         + FRAC_W'({fd_rem, 1'b0} >= {1'b0, fd_side.den});
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_fd_next[i] = 43'($signed({1'b0, s5_frac_reg})) * 43'($signed(s5_d_reg[i]));
        end
    end

    // Closest point per axis in Q.16, then magnitude rounded to Q.4.
    always_comb
    begin
        logic [42:0] m;
        logic [42:0] mag;
        logic [42:0] rnd;
        for (int i = 0; i < 3; i++)
        begin
            m   = (43'($signed(s6_p0_reg[i])) <<< 16) + s6_fd_reg[i];
            mag = m[42] ? -m : m;
            rnd = mag + 43'd2048;
            s7_a_next[i] = rnd[39:12];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s8_sq_next[i] = 56'(s7_a_reg[i]) * 56'(s7_a_reg[i]);
        end
    end

    assign s9_s_next = s8_sq_reg[0] + s8_sq_reg[1] + s8_sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_frac_reg <= s5_frac_next;
            s5_p0_reg   <= fd_side.p0;
            s5_d_reg    <= fd_side.d;
            s5_den_reg  <= fd_side.den;
            s6_frac_reg <= s5_frac_reg;
            s6_p0_reg   <= s5_p0_reg;
            s6_den_reg  <= s5_den_reg;
            s6_fd_reg   <= s6_fd_next;
            s7_frac_reg <= s6_frac_reg;
            s7_den_reg  <= s6_den_reg;
            s7_a_reg    <= s7_a_next;
            s8_frac_reg <= s7_frac_reg;
            s8_den_reg  <= s7_den_reg;
            s8_sq_reg   <= s8_sq_next;
            s9_frac_reg <= s8_frac_reg;
            s9_den_reg  <= s8_den_reg;
            s9_s_reg    <= s9_s_next;
        end
    end

    sca_isqrt #(
        .W  (SQRT_IN_W),
        .SW (FRAC_W)
    ) u_miss_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_vld_reg),
        .in_x      ({2'b00, s9_s_reg}),
        .in_side   (s9_frac_reg),
        .out_valid (sq_vld),
        .out_root  (sq_miss_root),
        .out_side  (sq_frac)
    );

    sca_isqrt #(
        .W  (SQRT_IN_W),
        .SW (1)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_vld_reg),
        .in_x      ({s9_den_reg, 8'h00}),
        .in_side   (1'b0),
        .out_valid (),
        .out_root  (sq_len_root),
        .out_side  ()
    );

    assign s10_rounded   = {1'b0, sq_miss_root} + (SQRT_OUT_W+1)'(8);
    assign s10_miss_next = (|s10_rounded[SQRT_OUT_W:MISS_W+4]) ? MISS_MAX
                                                               : s10_rounded[MISS_W+3:4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_miss_reg            <= s10_miss_next;
            s10_fuze_hit_reg        <= s10_miss_next <= fuze_reg;
            s10_frac_reg            <= sq_frac;
            s10_lm_reg              <= 39'(sq_len_root) * 39'(MS_PER_S);
            s11_side_reg.miss       <= s10_miss_reg;
            s11_side_reg.fuze_hit   <= s10_fuze_hit_reg;
            s11_side_reg.frac       <= s10_frac_reg;
            s11_dividend_reg        <= CDIV_QW'(s10_lm_reg) + CDIV_QW'({tick_reg, 3'b000});
        end
    end

    sca_divider #(
        .DW (CDIV_DW),
        .QW (CDIV_QW),
        .SW ($bits(close_side_t))
    ) u_closure_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s11_vld_reg),
        .in_div    ({tick_reg, 4'b0000}),
        .in_rem    ('0),
        .in_bits   (s11_dividend_reg),
        .in_side   (s11_side_reg),
        .out_valid (cd_vld),
        .out_quo   (cd_quo),
        .out_rem   (),
        .out_side  (cd_side_bits)
    );

    assign cd_side = close_side_t'(cd_side_bits);

    always_comb
    begin
        if (tick_reg == '0)
        begin
            closure_next = '0;
        end
        else if (|cd_quo[CDIV_QW-1:CLOSURE_W])
        begin
            closure_next = CLOSURE_MAX;
        end
        else
        begin
            closure_next = cd_quo[CLOSURE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {6'b000000, cd_side.fuze_hit, cd_side.frac, closure_next,
                             cd_side.miss};
        end
    end

endmodule
